// ===== src/integer_alu_with_poison_flags_assert.svh =====
// ---------------------------------------------------------------------------
// Integer ALU assertion macros
// Implication helpers for the assertions of the top-level RTL file.
// ---------------------------------------------------------------------------
`ifndef INTEGER_ALU_WITH_POISON_FLAGS_ASSERT_SVH
`define INTEGER_ALU_WITH_POISON_FLAGS_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define IAL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define IAL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ial_pkg.sv =====
// ---------------------------------------------------------------------------
// Integer ALU package
// Opcodes, stage records and sizes shared across the ALU pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ial_pkg;

    localparam int DATA_W    = 64;
    localparam int MAX_WIDTH = 64;
    localparam int DIV_STEPS = DATA_W;
    // stage 1 prep, stage 2 execute, 64 divide steps, then the back stage
    localparam int LAST_PIPE = 2 + DIV_STEPS;
    localparam int MUL_MERGE = 4;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_MUL  = 5'd2,
        OP_AND  = 5'd3,
        OP_OR   = 5'd4,
        OP_XOR  = 5'd5,
        OP_SHL  = 5'd6,
        OP_LSHR = 5'd7,
        OP_ASHR = 5'd8,
        OP_UDIV = 5'd9,
        OP_UREM = 5'd10,
        OP_SDIV = 5'd11,
        OP_SREM = 5'd12,
        OP_EQ   = 5'd13,
        OP_NE   = 5'd14,
        OP_UGT  = 5'd15,
        OP_UGE  = 5'd16,
        OP_ULT  = 5'd17,
        OP_ULE  = 5'd18,
        OP_SGT  = 5'd19,
        OP_SGE  = 5'd20,
        OP_SLT  = 5'd21,
        OP_SLE  = 5'd22
    } t_op;

    typedef struct packed {
        logic [4:0]        op;
        logic [6:0]        bits;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] top;
        logic [DATA_W-1:0] ul;
        logic [DATA_W-1:0] ur;
        logic [DATA_W-1:0] sl;
        logic [DATA_W-1:0] sr;
        logic              nuw;
        logic              nsw;
        logic              exact;
        logic              poison;
    } t_opnd;

    typedef struct packed {
        logic [4:0]        op;
        logic [DATA_W-1:0] mask;
        logic              exact;
        logic              poison;
        logic              trap;
        logic [DATA_W-1:0] res;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] dvs;
        logic              neg_q;
        logic              neg_r;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] res;
        logic              pois;
    } t_mul_res;

    typedef struct packed {
        logic valid;
        logic en;
    } t_back_ctl;

    function automatic logic is_div_op(input logic [4:0] op);
        is_div_op = (op == OP_UDIV) || (op == OP_UREM) || (op == OP_SDIV) || (op == OP_SREM);
    endfunction

endpackage

// ===== src/ial_prep.sv =====
// ---------------------------------------------------------------------------
// Integer ALU operand preparation
// Clamps the width, builds the masks and reduces both operands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ial_prep import ial_pkg::*; #(
    parameter int MAX_WIDTH = ial_pkg::MAX_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [4:0]        i_op,
    input  logic [6:0]        i_width,
    input  logic [DATA_W-1:0] i_lhs,
    input  logic [DATA_W-1:0] i_rhs,
    input  logic              i_nuw,
    input  logic              i_nsw,
    input  logic              i_exact,
    input  logic              i_poison_in,
    output t_opnd             o_opnd
);

    t_opnd r_opnd;
    t_opnd n_opnd;

    always_comb begin
        logic [6:0] bits;
        if (i_width == 7'd0) begin
            bits = 7'd1;
        end else if (i_width > 7'(MAX_WIDTH)) begin
            bits = 7'(MAX_WIDTH);
        end else begin
            bits = i_width;
        end
        n_opnd.op     = i_op;
        n_opnd.bits   = bits;
        n_opnd.mask   = {DATA_W{1'b1}} >> (7'(DATA_W) - bits);
        n_opnd.top    = {{(DATA_W-1){1'b0}}, 1'b1} << (bits - 7'd1);
        n_opnd.ul     = i_lhs & n_opnd.mask;
        n_opnd.ur     = i_rhs & n_opnd.mask;
        n_opnd.sl     = n_opnd.ul | (((n_opnd.ul & n_opnd.top) != '0) ? ~n_opnd.mask : '0);
        n_opnd.sr     = n_opnd.ur | (((n_opnd.ur & n_opnd.top) != '0) ? ~n_opnd.mask : '0);
        n_opnd.nuw    = i_nuw;
        n_opnd.nsw    = i_nsw;
        n_opnd.exact  = i_exact;
        n_opnd.poison = i_poison_in;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_opnd <= n_opnd;
        end
    end

    assign o_opnd = r_opnd;

endmodule

// ===== src/ial_exec.sv =====
// ---------------------------------------------------------------------------
// Integer ALU execute stage
// Add/sub, bitwise, shift and compare ops with their poison checks, and divider set-up.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ial_exec import ial_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_opnd i_opnd,
    output t_item o_item
);

    t_item r_item;
    t_item n_item;

    always_comb begin
        logic [DATA_W:0]   sum;
        logic [DATA_W-1:0] dif;
        logic [DATA_W-1:0] shl;
        logic [DATA_W-1:0] shl_sx;
        logic [DATA_W-1:0] lsr;
        logic [DATA_W-1:0] asr;
        logic [5:0]        sh;
        logic              big_sh;
        logic              cmp;
        logic              ln;
        logic              rn;
        sum    = {1'b0, i_opnd.ul} + {1'b0, i_opnd.ur};
        dif    = (i_opnd.ul - i_opnd.ur) & i_opnd.mask;
        sh     = i_opnd.ur[5:0];
        big_sh = i_opnd.ur >= {57'd0, i_opnd.bits};
        shl    = (i_opnd.ul << sh) & i_opnd.mask;
        shl_sx = shl | (((shl & i_opnd.top) != '0) ? ~i_opnd.mask : '0);
        lsr    = i_opnd.ul >> sh;
        asr    = DATA_W'($signed(i_opnd.sl) >>> sh) & i_opnd.mask;
        ln     = i_opnd.sl[DATA_W-1];
        rn     = i_opnd.sr[DATA_W-1];
        cmp    = 1'b0;

        n_item.op     = i_opnd.op;
        n_item.mask   = i_opnd.mask;
        n_item.exact  = i_opnd.exact;
        n_item.poison = i_opnd.poison;
        n_item.trap   = 1'b0;
        n_item.res    = '0;
        n_item.rem    = '0;
        n_item.quo    = i_opnd.ul;
        n_item.dvs    = i_opnd.ur;
        n_item.neg_q  = 1'b0;
        n_item.neg_r  = 1'b0;

        case (t_op'(i_opnd.op))
            OP_ADD: begin
                n_item.res = sum[DATA_W-1:0] & i_opnd.mask;
                if (i_opnd.nuw && ((sum & ~{1'b0, i_opnd.mask}) != '0)) begin
                    n_item.poison = 1'b1;
                end
                if (i_opnd.nsw && (((i_opnd.ul ^ n_item.res) & (i_opnd.ur ^ n_item.res)
                        & i_opnd.top) != '0)) begin
                    n_item.poison = 1'b1;
                end
            end
            OP_SUB: begin
                n_item.res = dif;
                if (i_opnd.nuw && (i_opnd.ul < i_opnd.ur)) begin
                    n_item.poison = 1'b1;
                end
                if (i_opnd.nsw && (((i_opnd.ul ^ i_opnd.ur) & (i_opnd.ul ^ dif)
                        & i_opnd.top) != '0)) begin
                    n_item.poison = 1'b1;
                end
            end
            OP_MUL: begin
                // product and its wrap checks join at the merge stage
                n_item.res = '0;
            end
            OP_AND: n_item.res = i_opnd.ul & i_opnd.ur;
            OP_OR:  n_item.res = i_opnd.ul | i_opnd.ur;
            OP_XOR: n_item.res = i_opnd.ul ^ i_opnd.ur;
            OP_SHL: begin
                if (big_sh) begin
                    n_item.poison = 1'b1;
                end else begin
                    n_item.res = shl;
                    if (i_opnd.nuw && ((shl >> sh) != i_opnd.ul)) begin
                        n_item.poison = 1'b1;
                    end
                    if (i_opnd.nsw && (DATA_W'($signed(shl_sx) >>> sh) != i_opnd.sl)) begin
                        n_item.poison = 1'b1;
                    end
                end
            end
            OP_LSHR: begin
                if (big_sh) begin
                    n_item.poison = 1'b1;
                end else begin
                    n_item.res = lsr;
                    if (i_opnd.exact && (((lsr << sh) & i_opnd.mask) != i_opnd.ul)) begin
                        n_item.poison = 1'b1;
                    end
                end
            end
            OP_ASHR: begin
                if (big_sh) begin
                    n_item.poison = 1'b1;
                end else begin
                    n_item.res = asr;
                    if (i_opnd.exact && (((asr << sh) & i_opnd.mask) != i_opnd.ul)) begin
                        n_item.poison = 1'b1;
                    end
                end
            end
            OP_UDIV, OP_UREM: begin
                n_item.trap = (i_opnd.ur == '0);
            end
            OP_SDIV, OP_SREM: begin
                n_item.trap = (i_opnd.ur == '0)
                    || ((i_opnd.sl == (~i_opnd.mask | i_opnd.top)) && (i_opnd.sr == '1));
                n_item.quo   = ln ? -i_opnd.sl : i_opnd.sl;
                n_item.dvs   = rn ? -i_opnd.sr : i_opnd.sr;
                n_item.neg_q = ln ^ rn;
                n_item.neg_r = ln;
            end
            OP_EQ, OP_NE, OP_UGT, OP_UGE, OP_ULT, OP_ULE,
            OP_SGT, OP_SGE, OP_SLT, OP_SLE: begin
                case (t_op'(i_opnd.op))
                    OP_EQ:   cmp = i_opnd.ul == i_opnd.ur;
                    OP_NE:   cmp = i_opnd.ul != i_opnd.ur;
                    OP_UGT:  cmp = i_opnd.ul >  i_opnd.ur;
                    OP_UGE:  cmp = i_opnd.ul >= i_opnd.ur;
                    OP_ULT:  cmp = i_opnd.ul <  i_opnd.ur;
                    OP_ULE:  cmp = i_opnd.ul <= i_opnd.ur;
                    OP_SGT:  cmp = $signed(i_opnd.sl) >  $signed(i_opnd.sr);
                    OP_SGE:  cmp = $signed(i_opnd.sl) >= $signed(i_opnd.sr);
                    OP_SLT:  cmp = $signed(i_opnd.sl) <  $signed(i_opnd.sr);
                    default: cmp = $signed(i_opnd.sl) <= $signed(i_opnd.sr);
                endcase
                n_item.res = cmp ? i_opnd.mask : '0;
            end
            default: begin
                // unused opcode: drop any incoming poison
                n_item.res    = '0;
                n_item.poison = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ===== src/ial_mul.sv =====
// ---------------------------------------------------------------------------
// Integer ALU multiplier
// Three-stage 64x64 multiply from 32x32 partials, with wrap checks.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ial_mul import ial_pkg::*; (
    input  logic     i_clk,
    input  logic     i_en,
    input  t_opnd    i_opnd,
    output t_mul_res o_mul
);

    localparam int HW = DATA_W / 2;
    localparam int PW = 2 * DATA_W;

    // partial products: unsigned view and signed-operand view
    logic [DATA_W-1:0] r_pu [4];
    logic [DATA_W-1:0] r_ps [4];
    logic [DATA_W-1:0] r_corr;
    logic [DATA_W-1:0] r_mask_a;
    logic              r_nuw_a;
    logic              r_nsw_a;

    logic [PW-1:0]     r_pu_b;
    logic [PW-1:0]     r_ps_b;
    logic [DATA_W-1:0] r_mask_b;
    logic              r_nuw_b;
    logic              r_nsw_b;

    t_mul_res          r_out;
    t_mul_res          n_out;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pu[0]  <= DATA_W'(i_opnd.ul[HW-1:0]      * i_opnd.ur[HW-1:0]);
            r_pu[1]  <= DATA_W'(i_opnd.ul[HW-1:0]      * i_opnd.ur[DATA_W-1:HW]);
            r_pu[2]  <= DATA_W'(i_opnd.ul[DATA_W-1:HW] * i_opnd.ur[HW-1:0]);
            r_pu[3]  <= DATA_W'(i_opnd.ul[DATA_W-1:HW] * i_opnd.ur[DATA_W-1:HW]);
            r_ps[0]  <= DATA_W'(i_opnd.sl[HW-1:0]      * i_opnd.sr[HW-1:0]);
            r_ps[1]  <= DATA_W'(i_opnd.sl[HW-1:0]      * i_opnd.sr[DATA_W-1:HW]);
            r_ps[2]  <= DATA_W'(i_opnd.sl[DATA_W-1:HW] * i_opnd.sr[HW-1:0]);
            r_ps[3]  <= DATA_W'(i_opnd.sl[DATA_W-1:HW] * i_opnd.sr[DATA_W-1:HW]);
            r_corr   <= (i_opnd.sl[DATA_W-1] ? i_opnd.sr : '0)
                      + (i_opnd.sr[DATA_W-1] ? i_opnd.sl : '0);
            r_mask_a <= i_opnd.mask;
            r_nuw_a  <= i_opnd.nuw;
            r_nsw_a  <= i_opnd.nsw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pu_b   <= {{DATA_W{1'b0}}, r_pu[0]} + ({{DATA_W{1'b0}}, r_pu[1]} << HW)
                      + ({{DATA_W{1'b0}}, r_pu[2]} << HW) + {r_pu[3], {DATA_W{1'b0}}};
            // signed product: take the sign corrections off the high half
            r_ps_b   <= {{DATA_W{1'b0}}, r_ps[0]} + ({{DATA_W{1'b0}}, r_ps[1]} << HW)
                      + ({{DATA_W{1'b0}}, r_ps[2]} << HW) + {r_ps[3], {DATA_W{1'b0}}}
                      - {r_corr, {DATA_W{1'b0}}};
            r_mask_b <= r_mask_a;
            r_nuw_b  <= r_nuw_a;
            r_nsw_b  <= r_nsw_a;
        end
    end

    always_comb begin
        logic [PW-1:0] fold;
        logic          ovu;
        logic          ovs;
        ovu        = (r_pu_b & ~{{DATA_W{1'b0}}, r_mask_b}) != '0;
        fold       = r_ps_b ^ {PW{r_ps_b[PW-1]}};
        ovs        = (fold & ~{{DATA_W{1'b0}}, r_mask_b >> 1}) != '0;
        n_out.res  = r_pu_b[DATA_W-1:0] & r_mask_b;
        n_out.pois = (r_nuw_b & ovu) | (r_nsw_b & ovs);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_mul = r_out;

endmodule

// ===== src/ial_div_step.sv =====
// ---------------------------------------------------------------------------
// Integer ALU divide step
// One restoring quotient bit per stage; other items pass through.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ial_div_step import ial_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_item i_item,
    output t_item o_item
);

    t_item r_item;
    t_item n_item;

    always_comb begin
        logic [DATA_W:0] trial;
        n_item = i_item;
        trial  = {i_item.rem, i_item.quo[DATA_W-1]} - {1'b0, i_item.dvs};
        if (!trial[DATA_W]) begin
            n_item.rem = trial[DATA_W-1:0];
            n_item.quo = {i_item.quo[DATA_W-2:0], 1'b1};
        end else begin
            n_item.rem = {i_item.rem[DATA_W-2:0], i_item.quo[DATA_W-1]};
            n_item.quo = {i_item.quo[DATA_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ===== src/ial_back.sv =====
// ---------------------------------------------------------------------------
// Integer ALU back end
// Signs quotient and remainder, checks exact divides, applies trap and
// sign-extends; a skid register keeps the pipeline moving as a stall begins.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ial_back import ial_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  t_item                    i_item,
    input  logic                     i_ready,
    output t_back_ctl                o_ctl,
    output logic signed [DATA_W-1:0] o_result,
    output logic                     o_poison,
    output logic                     o_trap
);

    logic              r_vld;
    logic              r_skid_vld;
    logic [DATA_W-1:0] r_res;
    logic              r_pois;
    logic              r_trap;
    logic [DATA_W-1:0] r_skid_res;
    logic              r_skid_pois;
    logic              r_skid_trap;
    logic [DATA_W-1:0] n_res;
    logic              n_pois;
    logic              w_en;

    assign w_en = !r_skid_vld;

    always_comb begin
        logic [DATA_W-1:0] q;
        logic [DATA_W-1:0] r;
        logic [DATA_W-1:0] v;
        logic [DATA_W-1:0] top;
        q      = i_item.neg_q ? -i_item.quo : i_item.quo;
        r      = i_item.neg_r ? -i_item.rem : i_item.rem;
        v      = i_item.res;
        n_pois = i_item.poison;
        if (is_div_op(i_item.op)) begin
            if ((i_item.op == OP_UDIV) || (i_item.op == OP_SDIV)) begin
                v = q;
                if (i_item.exact && (r != '0)) begin
                    n_pois = 1'b1;
                end
            end else begin
                v = r;
            end
        end
        v = v & i_item.mask;
        if (i_item.trap) begin
            v      = '0;
            n_pois = 1'b0;
        end
        top   = i_item.mask ^ (i_item.mask >> 1);
        n_res = v | (((v & top) != '0) ? ~i_item.mask : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld <= i_vld;
            end
            if (r_skid_vld) begin
                r_skid_vld <= !i_ready;
            end else begin
                // park the waiting item while the pipeline advances
                r_skid_vld <= r_vld && !i_ready;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res       <= n_res;
            r_pois      <= n_pois;
            r_trap      <= i_item.trap;
            r_skid_res  <= r_res;
            r_skid_pois <= r_pois;
            r_skid_trap <= r_trap;
        end
    end

    assign o_ctl.valid = r_skid_vld || r_vld;
    assign o_ctl.en    = w_en;
    assign o_result    = r_skid_vld ? r_skid_res  : r_res;
    assign o_poison    = r_skid_vld ? r_skid_pois : r_pois;
    assign o_trap      = r_skid_vld ? r_skid_trap : r_trap;

endmodule

// ===== src/integer_alu_with_poison_flags.sv =====
// ---------------------------------------------------------------------------
// Integer ALU with poison flags
// Pipelined integer ALU: add/sub/mul with wrap checks, bitwise, shifts,
// divides and compares at operand widths of 1 to 64 bits.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_ready   i_op i_width i_lhs i_rhs i_nuw
//                                            i_nsw i_exact i_poison_in
//   output    out        o_valid / i_ready   o_result o_poison o_trap
//
// Every item, whatever the op, passes through prep, execute, the 64 divide
// steps (one quotient bit per stage) and the back stage before o_valid.
// One item is accepted per cycle while o_ready is high; items leave in order.
// A skid register after the last stage takes one waiting result, so
// o_ready stays high as a stall begins and drops once the skid is full.
// Reset clears only the valid bits; no clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_alu_with_poison_flags import ial_pkg::*; #(
    parameter int MAX_WIDTH = ial_pkg::MAX_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [4:0]               i_op,
    input  logic [6:0]               i_width,
    input  logic [DATA_W-1:0]        i_lhs,
    input  logic [DATA_W-1:0]        i_rhs,
    input  logic                     i_nuw,
    input  logic                     i_nsw,
    input  logic                     i_exact,
    input  logic                     i_poison_in,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_result,
    output logic                     o_poison,
    output logic                     o_trap
);

    `include "integer_alu_with_poison_flags_assert.svh"

    logic [LAST_PIPE:1] r_vld;
    t_opnd              w_opnd;
    t_item              w_item [2:LAST_PIPE];
    t_item              w_merge;
    t_mul_res           w_mul;
    t_back_ctl          w_ctl;
    logic               w_en;

    assign w_en    = w_ctl.en;
    assign o_ready = w_en;
    assign o_valid = w_ctl.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST_PIPE-1:1], i_valid};
        end
    end

    ial_prep #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_prep (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_op        (i_op),
        .i_width     (i_width),
        .i_lhs       (i_lhs),
        .i_rhs       (i_rhs),
        .i_nuw       (i_nuw),
        .i_nsw       (i_nsw),
        .i_exact     (i_exact),
        .i_poison_in (i_poison_in),
        .o_opnd      (w_opnd)
    );

    ial_exec u_exec (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_opnd (w_opnd),
        .o_item (w_item[2])
    );

    ial_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_opnd (w_opnd),
        .o_mul  (w_mul)
    );

    // product lines up with this stage; fold it into the item
    always_comb begin
        w_merge = w_item[MUL_MERGE];
        if (w_item[MUL_MERGE].op == OP_MUL) begin
            w_merge.res    = w_mul.res;
            w_merge.poison = w_item[MUL_MERGE].poison | w_mul.pois;
        end
    end

    for (genvar k = 2; k < LAST_PIPE; k++) begin : g_div
        if (k == MUL_MERGE) begin : g_merge
            ial_div_step u_step (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_item (w_merge),
                .o_item (w_item[k+1])
            );
        end else begin : g_plain
            ial_div_step u_step (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_item (w_item[k]),
                .o_item (w_item[k+1])
            );
        end
    end

    ial_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_vld[LAST_PIPE]),
        .i_item   (w_item[LAST_PIPE]),
        .i_ready  (i_ready),
        .o_ctl    (w_ctl),
        .o_result (o_result),
        .o_poison (o_poison),
        .o_trap   (o_trap)
    );

    `IAL_ASSERT_IMP(a_trap_clean, i_clk, i_rst_n, o_valid && o_trap,
        !o_poison && (o_result == '0), "trap result carries value or poison")

    `IAL_ASSERT_IMP(a_trap_div_only, i_clk, i_rst_n, r_vld[2] && w_item[2].trap,
        (w_item[2].op == OP_UDIV) || (w_item[2].op == OP_UREM)
        || (w_item[2].op == OP_SDIV) || (w_item[2].op == OP_SREM),
        "trap raised by a non-divide op")

    `IAL_ASSERT_IMP(a_ready_when_drained, i_clk, i_rst_n, !o_valid, o_ready,
        "input stalled with no result waiting")

    `IAL_ASSERT_NXT(a_skid_catch, i_clk, i_rst_n, o_ready && o_valid && !i_ready,
        !o_ready && o_valid, "waiting result not parked in skid")

endmodule
